@@ design/ldfa_pkg.sv @@
// shared types, constants and codes for the lexer automaton
package ldfa_pkg;

    localparam int MAX_STATES  = 64;
    localparam int MAX_COLUMNS = 32;
    localparam int ALPHA_SLOTS = 64;

    localparam int STATE_W = $clog2(MAX_STATES);
    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int SLOT_W  = $clog2(ALPHA_SLOTS);
    localparam int ADDR_W  = STATE_W + COL_W;

    // fixed widths of the configuration registers and item fields
    localparam int NUM_STATES_W  = 7;
    localparam int NUM_COLUMNS_W = 6;
    localparam int NUM_SYMBOLS_W = 7;
    localparam int CMD_W         = 3;
    localparam int SYM_W         = 8;
    localparam int ROW_W         = 6;
    localparam int COLIDX_W      = 5;
    localparam int TGT_W         = 8;
    localparam int IN_DATA_W     = 40;
    localparam int OUT_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 7;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam logic [QPTR_W:0] QUEUE_FULL = (QPTR_W + 1)'(QUEUE_DEPTH);

    localparam logic [NUM_STATES_W-1:0]  STATES_CAP  = NUM_STATES_W'(MAX_STATES);
    localparam logic [NUM_COLUMNS_W-1:0] COLUMNS_CAP = NUM_COLUMNS_W'(MAX_COLUMNS);
    localparam logic [NUM_SYMBOLS_W-1:0] SLOTS_CAP   = NUM_SYMBOLS_W'(ALPHA_SLOTS);

    typedef enum logic [CMD_W-1:0] {
        CMD_STEP   = 3'd0,
        CMD_ALPHA  = 3'd1,
        CMD_TRANS  = 3'd2,
        CMD_ACCEPT = 3'd3,
        CMD_RESET  = 3'd4
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NUM_STATES  = 2'd0,
        CFG_NUM_COLUMNS = 2'd1,
        CFG_NUM_SYMBOLS = 2'd2,
        CFG_START_STATE = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        OP_STEP,
        OP_TRANS,
        OP_ACCEPT,
        OP_RESET
    } op_t;

    localparam logic [1:0] ST_CONTINUE = 2'd0;
    localparam logic [1:0] ST_ACCEPT   = 2'd1;
    localparam logic [1:0] ST_FAIL     = 2'd2;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ1,
        BK_READ2
    } back_state_t;

    // one classified command between front and back
    typedef struct packed {
        op_t                     op;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [TGT_W-1:0] target;
        logic                    flag;
        logic                    found;
        logic                    col_err;
        logic                    la_ok;
        logic [COL_W-1:0]        la_col;
    } entry_t;

    // status in the lowest bits
    typedef struct packed {
        logic [STATE_W-1:0] state_now;
        logic               error_flag;
        logic [1:0]         status;
    } result_t;

endpackage

@@ design/ldfa_front.sv @@
// front end: alphabet slots, character classification and command decode
module ldfa_front
(
    input  logic                                  clk,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [ldfa_pkg::CMD_W-1:0]            in_cmd,
    input  logic [ldfa_pkg::IN_DATA_W-1:0]        in_data,
    input  logic [ldfa_pkg::NUM_COLUMNS_W-1:0]    num_columns,
    input  logic [ldfa_pkg::NUM_SYMBOLS_W-1:0]    num_symbols,
    output logic                                  push_valid,
    input  logic                                  push_ready,
    output ldfa_pkg::entry_t                      push_entry
);

    logic [ldfa_pkg::SYM_W-1:0]    symbol;
    logic                          la_valid;
    logic [ldfa_pkg::SYM_W-1:0]    la_symbol;
    logic [ldfa_pkg::ROW_W-1:0]    row_index;
    logic [ldfa_pkg::COLIDX_W-1:0] column_index;
    logic signed [ldfa_pkg::TGT_W-1:0] target_state;
    logic                          accept_flag;

    logic [ldfa_pkg::SYM_W-1:0] sym_reg  [ldfa_pkg::ALPHA_SLOTS];
    logic [ldfa_pkg::COL_W-1:0] scol_reg [ldfa_pkg::ALPHA_SLOTS];

    logic [ldfa_pkg::NUM_SYMBOLS_W-1:0] limit;
    logic [ldfa_pkg::NUM_SYMBOLS_W-1:0] limit_raw;
    logic [ldfa_pkg::NUM_COLUMNS_W-1:0] cols_used;
    logic [ldfa_pkg::ALPHA_SLOTS-1:0]   hit_c;
    logic [ldfa_pkg::ALPHA_SLOTS-1:0]   hit_l;
    logic [ldfa_pkg::ALPHA_SLOTS-1:0]   first_c;
    logic [ldfa_pkg::ALPHA_SLOTS-1:0]   first_l;
    logic [ldfa_pkg::COL_W-1:0]         col_c;
    logic [ldfa_pkg::COL_W-1:0]         col_l;
    logic                               found_c;
    logic                               found_l;
    logic                               col_err_c;
    logic                               col_err_l;
    logic                               push_needed;
    logic                               alpha_wr;

    assign symbol       = in_data[7:0];
    assign la_valid     = in_data[8];
    assign la_symbol    = in_data[16:9];
    assign row_index    = in_data[22:17];
    assign column_index = in_data[27:23];
    assign target_state = in_data[35:28];
    assign accept_flag  = in_data[36];

    // zero slot count falls back to the column count
    assign limit_raw = (num_symbols != '0) ? num_symbols
                                           : ldfa_pkg::NUM_SYMBOLS_W'(num_columns);
    assign limit     = (limit_raw > ldfa_pkg::SLOTS_CAP) ? ldfa_pkg::SLOTS_CAP : limit_raw;
    assign cols_used = (num_columns > ldfa_pkg::COLUMNS_CAP) ? ldfa_pkg::COLUMNS_CAP
                                                              : num_columns;

    always_comb
    begin
        for (int i = 0; i < ldfa_pkg::ALPHA_SLOTS; i++)
        begin
            hit_c[i] = (sym_reg[i] == symbol) && (ldfa_pkg::NUM_SYMBOLS_W'(i) < limit);
            hit_l[i] = (sym_reg[i] == la_symbol) && (ldfa_pkg::NUM_SYMBOLS_W'(i) < limit);
        end
    end

    // isolate the lowest matching slot
    assign first_c = hit_c & (~hit_c + 1'b1);
    assign first_l = hit_l & (~hit_l + 1'b1);

    always_comb
    begin
        col_c = '0;
        col_l = '0;
        for (int i = 0; i < ldfa_pkg::ALPHA_SLOTS; i++)
        begin
            col_c = col_c | (first_c[i] ? scol_reg[i] : '0);
            col_l = col_l | (first_l[i] ? scol_reg[i] : '0);
        end
    end

    assign found_c   = |hit_c;
    assign found_l   = |hit_l;
    assign col_err_c = ldfa_pkg::NUM_COLUMNS_W'(col_c) >= cols_used;
    assign col_err_l = ldfa_pkg::NUM_COLUMNS_W'(col_l) >= cols_used;

    always_comb
    begin
        push_needed        = 1'b0;
        push_entry.op      = ldfa_pkg::OP_STEP;
        push_entry.row     = row_index;
        push_entry.col     = column_index;
        push_entry.target  = target_state;
        push_entry.flag    = accept_flag;
        push_entry.found   = found_c;
        push_entry.col_err = col_err_c;
        push_entry.la_ok   = la_valid && found_l && !col_err_l;
        push_entry.la_col  = col_l;
        case (ldfa_pkg::cmd_t'(in_cmd))
            ldfa_pkg::CMD_STEP:
            begin
                push_needed    = 1'b1;
                push_entry.col = col_c;
            end
            ldfa_pkg::CMD_TRANS:
            begin
                push_needed   = 1'b1;
                push_entry.op = ldfa_pkg::OP_TRANS;
            end
            ldfa_pkg::CMD_ACCEPT:
            begin
                push_needed   = 1'b1;
                push_entry.op = ldfa_pkg::OP_ACCEPT;
            end
            ldfa_pkg::CMD_RESET:
            begin
                push_needed   = 1'b1;
                push_entry.op = ldfa_pkg::OP_RESET;
            end
            default:
            begin
                push_needed = 1'b0;
            end
        endcase
    end

    assign in_ready   = push_ready;
    assign push_valid = in_valid && push_needed;
    assign alpha_wr   = in_valid && in_ready && (ldfa_pkg::cmd_t'(in_cmd) == ldfa_pkg::CMD_ALPHA);

    always_ff @(posedge clk)
    begin
        if (alpha_wr)
        begin
            sym_reg[row_index]  <= symbol;
            scol_reg[row_index] <= column_index;
        end
    end

endmodule

@@ design/ldfa_queue.sv @@
// short fifo of classified commands between front and back
module ldfa_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  ldfa_pkg::entry_t push_entry,
    output logic             pop_valid,
    input  logic             pop_ready,
    output ldfa_pkg::entry_t pop_entry
);

    ldfa_pkg::entry_t entries_reg [ldfa_pkg::QUEUE_DEPTH];

    logic [ldfa_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [ldfa_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [ldfa_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [ldfa_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [ldfa_pkg::QPTR_W:0]   count_reg;
    logic [ldfa_pkg::QPTR_W:0]   count_next;
    logic                        do_push;
    logic                        do_pop;

    assign push_ready = count_reg != ldfa_pkg::QUEUE_FULL;
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ design/ldfa_back.sv @@
// back end: transition ram, accept flags, current state and result register
module ldfa_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 pop_valid,
    output logic                                 pop_ready,
    input  ldfa_pkg::entry_t                     pop_entry,
    input  logic [ldfa_pkg::NUM_STATES_W-1:0]    num_states,
    input  logic [ldfa_pkg::STATE_W-1:0]         start_state,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output ldfa_pkg::result_t                    out_result
);

    logic [ldfa_pkg::TGT_W-1:0] mem [ldfa_pkg::MAX_STATES * ldfa_pkg::MAX_COLUMNS];
    logic [ldfa_pkg::TGT_W-1:0] rd_data_reg;

    ldfa_pkg::back_state_t state_reg;
    ldfa_pkg::back_state_t state_next;

    logic [ldfa_pkg::STATE_W-1:0]    cur_reg;
    logic [ldfa_pkg::STATE_W-1:0]    cur_next;
    logic [ldfa_pkg::MAX_STATES-1:0] accept_flags_reg;
    logic [ldfa_pkg::MAX_STATES-1:0] accept_flags_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    ldfa_pkg::result_t               out_result_reg;
    ldfa_pkg::result_t               out_result_next;
    logic                            la_ok_reg;
    logic                            la_ok_next;
    logic [ldfa_pkg::COL_W-1:0]      la_col_reg;
    logic [ldfa_pkg::COL_W-1:0]      la_col_next;

    logic [ldfa_pkg::NUM_STATES_W-1:0] states_used;
    logic                              out_free;
    logic                              pop_step;
    logic                              cur_bad;
    logic                              start_read;
    logic                              tgt_pos;
    logic                              tgt_big;
    logic                              tgt_ok;
    logic                              do_pop;
    logic                              res_load;
    ldfa_pkg::result_t                 res_value;
    logic                              rd_en;
    logic [ldfa_pkg::ADDR_W-1:0]       rd_addr;
    logic                              wr_en;

    assign states_used = (num_states > ldfa_pkg::STATES_CAP) ? ldfa_pkg::STATES_CAP
                                                              : num_states;
    assign out_free    = !out_valid_reg || out_ready;
    assign pop_step    = pop_entry.op == ldfa_pkg::OP_STEP;
    assign cur_bad     = ldfa_pkg::NUM_STATES_W'(cur_reg) >= states_used;
    assign start_read  = !cur_bad && pop_entry.found && !pop_entry.col_err;
    assign tgt_pos     = !rd_data_reg[ldfa_pkg::TGT_W-1] && (rd_data_reg != '0);
    assign tgt_big     = ldfa_pkg::NUM_STATES_W'(rd_data_reg[ldfa_pkg::TGT_W-2:0]) >= states_used;
    assign tgt_ok      = tgt_pos && !tgt_big;
    assign pop_ready   = (state_reg == ldfa_pkg::BK_IDLE) && (!pop_step || out_free);
    assign do_pop      = pop_valid && pop_ready;
    assign wr_en       = do_pop && (pop_entry.op == ldfa_pkg::OP_TRANS);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ldfa_pkg::BK_IDLE:
            begin
                if (do_pop && pop_step && start_read)
                begin
                    state_next = ldfa_pkg::BK_READ1;
                end
            end
            ldfa_pkg::BK_READ1:
            begin
                state_next = (tgt_ok && la_ok_reg) ? ldfa_pkg::BK_READ2 : ldfa_pkg::BK_IDLE;
            end
            ldfa_pkg::BK_READ2:
            begin
                state_next = ldfa_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = ldfa_pkg::BK_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cur_next             = cur_reg;
        accept_flags_next    = accept_flags_reg;
        la_ok_next           = la_ok_reg;
        la_col_next          = la_col_reg;
        res_load             = 1'b0;
        res_value.status     = ldfa_pkg::ST_FAIL;
        res_value.error_flag = 1'b0;
        res_value.state_now  = cur_reg;
        rd_en                = 1'b0;
        rd_addr              = {cur_reg, pop_entry.col};
        case (state_reg)
            ldfa_pkg::BK_IDLE:
            begin
                if (do_pop)
                begin
                    case (pop_entry.op)
                        ldfa_pkg::OP_STEP:
                        begin
                            la_ok_next  = pop_entry.la_ok;
                            la_col_next = pop_entry.la_col;
                            if (start_read)
                            begin
                                rd_en = 1'b1;
                            end
                            else
                            begin
                                // bad state, unknown character or bad column
                                res_load             = 1'b1;
                                res_value.error_flag = cur_bad
                                                       || (pop_entry.found && pop_entry.col_err);
                            end
                        end
                        ldfa_pkg::OP_ACCEPT:
                        begin
                            accept_flags_next[pop_entry.row] = pop_entry.flag;
                        end
                        ldfa_pkg::OP_RESET:
                        begin
                            cur_next = start_state;
                        end
                        default:
                        begin
                            cur_next = cur_reg;
                        end
                    endcase
                end
            end
            ldfa_pkg::BK_READ1:
            begin
                rd_addr = {rd_data_reg[ldfa_pkg::STATE_W-1:0], la_col_reg};
                if (!tgt_ok)
                begin
                    res_load             = 1'b1;
                    res_value.error_flag = tgt_pos && tgt_big;
                end
                else
                begin
                    cur_next = rd_data_reg[ldfa_pkg::STATE_W-1:0];
                    if (la_ok_reg)
                    begin
                        rd_en = 1'b1;
                    end
                    else
                    begin
                        res_load            = 1'b1;
                        res_value.state_now = rd_data_reg[ldfa_pkg::STATE_W-1:0];
                        res_value.status    = accept_flags_reg[rd_data_reg[ldfa_pkg::STATE_W-1:0]]
                                              ? ldfa_pkg::ST_ACCEPT : ldfa_pkg::ST_FAIL;
                    end
                end
            end
            ldfa_pkg::BK_READ2:
            begin
                res_load = 1'b1;
                if (tgt_ok)
                begin
                    res_value.status = ldfa_pkg::ST_CONTINUE;
                end
                else
                begin
                    res_value.status = accept_flags_reg[cur_reg] ? ldfa_pkg::ST_ACCEPT
                                                                 : ldfa_pkg::ST_FAIL;
                end
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
        out_valid_next  = res_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        out_result_next = res_load ? res_value : out_result_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ldfa_pkg::BK_IDLE;
            cur_reg          <= '0;
            accept_flags_reg <= '0;
            out_valid_reg    <= 1'b0;
            la_ok_reg        <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cur_reg          <= cur_next;
            accept_flags_reg <= accept_flags_next;
            out_valid_reg    <= out_valid_next;
            la_ok_reg        <= la_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_result_reg <= out_result_next;
        la_col_reg     <= la_col_next;
    end

    // transition ram, one write or read per cycle, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[{pop_entry.row, pop_entry.col}] <= pop_entry.target;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

    // result slot is always empty while a table walk is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ldfa_pkg::BK_IDLE) |-> !out_valid_reg)
        else $error("result slot busy during table walk");

    // a continue never carries the error flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_result_reg.status == ldfa_pkg::ST_CONTINUE)
        |-> !out_result_reg.error_flag)
        else $error("continue reported with error");

    // lookahead read only follows a successful first read
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ldfa_pkg::BK_READ2) |-> ($past(state_reg) == ldfa_pkg::BK_READ1))
        else $error("lookahead read without first read");

    // an accepted target becomes the current state
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ldfa_pkg::BK_READ1 && tgt_ok)
        |=> (cur_reg == $past(rd_data_reg[ldfa_pkg::STATE_W-1:0])))
        else $error("current state not advanced");

endmodule

@@ design/lexer_dfa_step_with_lookahead_unit.sv @@
// top level of the table-driven lexer automaton with one-character lookahead
//
// Load commands fill the alphabet (in the front end), the transition ram and the
// accept flags (in the back end); step commands return one result each, other
// commands none. The front end matches the character and the lookahead against the
// searched alphabet slots in the cycle it accepts a command and queues all but
// alphabet loads (4 deep). The back end answers a step that fails before the table
// in BK_IDLE, one with a transition read in BK_READ1 and one with the lookahead
// read in BK_READ2, set by the single port of the transition ram and its registered
// read; load and reset commands complete in BK_IDLE. No clearing pass follows reset:
// accept flags are cleared at once, other tables must be written before they are used.
module lexer_dfa_step_with_lookahead_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // symbol[7:0], lookahead_valid[8], lookahead_symbol[16:9], row_index[22:17],
    // column_index[27:23], target_state[35:28], accept_flag[36], zero[39:37]
    input  logic [ldfa_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // cmd[2:0]
    input  logic [ldfa_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status[1:0], error_flag[2], state_now[8:3], zero[15:9]
    output logic [ldfa_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ldfa_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ldfa_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [ldfa_pkg::NUM_STATES_W-1:0]  num_states_reg;
    logic [ldfa_pkg::NUM_COLUMNS_W-1:0] num_columns_reg;
    logic [ldfa_pkg::NUM_SYMBOLS_W-1:0] num_symbols_reg;
    logic [ldfa_pkg::STATE_W-1:0]       start_state_reg;

    logic              push_valid;
    logic              push_ready;
    ldfa_pkg::entry_t  push_entry;
    logic              pop_valid;
    logic              pop_ready;
    ldfa_pkg::entry_t  pop_entry;
    ldfa_pkg::result_t result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_states_reg  <= ldfa_pkg::NUM_STATES_W'(1);
            num_columns_reg <= ldfa_pkg::NUM_COLUMNS_W'(1);
            num_symbols_reg <= ldfa_pkg::NUM_SYMBOLS_W'(1);
            start_state_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (ldfa_pkg::cfg_index_t'(cfg_index))
                ldfa_pkg::CFG_NUM_STATES:  num_states_reg  <= cfg_data;
                ldfa_pkg::CFG_NUM_COLUMNS:
                    num_columns_reg <= cfg_data[ldfa_pkg::NUM_COLUMNS_W-1:0];
                ldfa_pkg::CFG_NUM_SYMBOLS: num_symbols_reg <= cfg_data;
                ldfa_pkg::CFG_START_STATE:
                    start_state_reg <= cfg_data[ldfa_pkg::STATE_W-1:0];
                default:                   num_states_reg  <= num_states_reg;
            endcase
        end
    end

    ldfa_front u_front
    (
        .clk         (clk),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_cmd      (s_axis_tuser),
        .in_data     (s_axis_tdata),
        .num_columns (num_columns_reg),
        .num_symbols (num_symbols_reg),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_entry  (push_entry)
    );

    ldfa_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    ldfa_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_entry   (pop_entry),
        .num_states  (num_states_reg),
        .start_state (start_state_reg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (result)
    );

    assign m_axis_tdata = {{(ldfa_pkg::OUT_DATA_W - $bits(ldfa_pkg::result_t)){1'b0}}, result};

endmodule

@@ verif/lexer_dfa_step_with_lookahead_unit_tb.sv @@
`timescale 1ns / 100ps
// testbench for the lexer automaton: predicting scoreboard, directed and random transactions
module lexer_dfa_step_with_lookahead_unit_tb;
    import ldfa_pkg::*;

    localparam int CYCLE_LIMIT  = 500_000;
    localparam int DRAIN_CYCLES = 24;
    localparam int TOTAL_ITEMS  = 1150;
    localparam int NUM_PHASES   = 9;
    localparam int MAX_PRINTS   = 100;

    localparam logic [SYM_W-1:0] CH_A = 8'h61;
    localparam logic [SYM_W-1:0] CH_B = 8'h62;
    localparam logic [SYM_W-1:0] CH_C = 8'h63;
    localparam logic [SYM_W-1:0] CH_Z = 8'h7a;

    typedef enum {LK_REJECT, LK_MOVE, LK_FAULT} lookup_t;

    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic [SYM_W-1:0]    sym;
        logic                la_valid;
        logic [SYM_W-1:0]    la_sym;
        logic [ROW_W-1:0]    row;
        logic [COLIDX_W-1:0] col;
        logic [TGT_W-1:0]    tgt;
        logic                flag;
    } lex_item_t;

    // state, columns, symbols and start state of each random phase, extremes included
    int phase_settings [NUM_PHASES][4] = '{
        '{8, 4, 16, 0},
        '{64, 32, 64, 63},
        '{127, 63, 127, 5},
        '{2, 1, 0, 1},
        '{0, 0, 1, 0},
        '{16, 8, 8, 40},
        '{1, 32, 64, 0},
        '{33, 5, 0, 31},
        '{12, 3, 100, 7}
    };

    class lexer_scoreboard;
        logic [NUM_STATES_W-1:0]  num_states;
        logic [NUM_COLUMNS_W-1:0] num_columns;
        logic [NUM_SYMBOLS_W-1:0] num_symbols;
        logic [STATE_W-1:0]       start_state;
        logic [STATE_W-1:0]       cur_state;
        logic [SYM_W-1:0]         alpha_sym [ALPHA_SLOTS];
        logic [COL_W-1:0]         alpha_col [ALPHA_SLOTS];
        logic [TGT_W-1:0]         trans [MAX_STATES * MAX_COLUMNS];
        bit                       trans_written [MAX_STATES * MAX_COLUMNS];
        bit                       accepting [MAX_STATES];
        result_t                  expected_q [$];
        int                       errors;

        function new();
            num_states  = 1;
            num_columns = 1;
            num_symbols = 1;
            start_state = 0;
            cur_state   = 0;
            errors      = 0;
            foreach (alpha_sym[i])
            begin
                alpha_sym[i] = '0;
                alpha_col[i] = '0;
            end
            foreach (trans[i])
            begin
                trans[i]         = '0;
                trans_written[i] = 1'b0;
            end
            foreach (accepting[i])
                accepting[i] = 1'b0;
        endfunction

        function int states_used();
            return (num_states > MAX_STATES) ? MAX_STATES : int'(num_states);
        endfunction

        function int columns_used();
            return (num_columns > MAX_COLUMNS) ? MAX_COLUMNS : int'(num_columns);
        endfunction

        function int slots_searched();
            int lim;
            lim = (num_symbols != 0) ? int'(num_symbols) : int'(num_columns);
            return (lim > ALPHA_SLOTS) ? ALPHA_SLOTS : lim;
        endfunction

        // addr is the table entry read, or -1 if none was read
        function lookup_t lookup(int from, logic [SYM_W-1:0] ch, output int next,
                                 output int addr);
            int ns;
            int tgt;
            ns   = states_used();
            next = from;
            addr = -1;
            if (from >= ns)
                return LK_FAULT;
            for (int i = 0; i < slots_searched(); i++)
            begin
                if (alpha_sym[i] == ch)
                begin
                    if (int'(alpha_col[i]) >= columns_used())
                        return LK_FAULT;
                    addr = from * MAX_COLUMNS + int'(alpha_col[i]);
                    tgt  = $signed(trans[addr]);
                    if (tgt <= 0)
                        return LK_REJECT;
                    if (tgt >= ns)
                        return LK_FAULT;
                    next = tgt;
                    return LK_MOVE;
                end
            end
            return LK_REJECT;
        endfunction

        // a step about to read a table entry that was never loaded
        function bit find_hole(lex_item_t it, output int addr);
            lookup_t r;
            int      nxt;
            int      la_next;
            addr = -1;
            if (it.cmd != CMD_STEP)
                return 1'b0;
            r = lookup(cur_state, it.sym, nxt, addr);
            if (addr >= 0 && !trans_written[addr])
                return 1'b1;
            if (r == LK_MOVE && it.la_valid)
            begin
                void'(lookup(nxt, it.la_sym, la_next, addr));
                if (addr >= 0 && !trans_written[addr])
                    return 1'b1;
            end
            addr = -1;
            return 1'b0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_NUM_STATES:  num_states  = value;
                CFG_NUM_COLUMNS: num_columns = value[NUM_COLUMNS_W-1:0];
                CFG_NUM_SYMBOLS: num_symbols = value;
                CFG_START_STATE: start_state = value[STATE_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_input(lex_item_t it);
            lookup_t r;
            int      nxt;
            int      la_next;
            int      addr;
            result_t res;
            case (it.cmd)
                CMD_ALPHA:
                begin
                    alpha_sym[it.row] = it.sym;
                    alpha_col[it.row] = it.col;
                end
                CMD_TRANS:
                begin
                    trans[int'(it.row) * MAX_COLUMNS + int'(it.col)]         = it.tgt;
                    trans_written[int'(it.row) * MAX_COLUMNS + int'(it.col)] = 1'b1;
                end
                CMD_ACCEPT: accepting[it.row] = it.flag;
                CMD_RESET:  cur_state = start_state;
                CMD_STEP:
                begin
                    r = lookup(cur_state, it.sym, nxt, addr);
                    res.error_flag = (r == LK_FAULT);
                    if (r == LK_MOVE)
                    begin
                        cur_state = nxt[STATE_W-1:0];
                        // lookahead faults only stop the continue, never flag an error
                        if (it.la_valid && lookup(cur_state, it.la_sym, la_next, addr) == LK_MOVE)
                            res.status = ST_CONTINUE;
                        else if (accepting[cur_state])
                            res.status = ST_ACCEPT;
                        else
                            res.status = ST_FAIL;
                    end
                    else
                        res.status = ST_FAIL;
                    res.state_now = cur_state;
                    expected_q.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_result(logic [OUT_DATA_W-1:0] data);
            result_t got;
            result_t want;
            got = result_t'(data[$bits(result_t)-1:0]);
            if (expected_q.size() == 0)
            begin
                report("result transaction with nothing expected");
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.error_flag !== want.error_flag)
                report($sformatf("error_flag %0d, expected %0d", got.error_flag,
                                 want.error_flag));
            if (got.state_now !== want.state_now)
                report($sformatf("state_now %0d, expected %0d", got.state_now,
                                 want.state_now));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [CMD_W-1:0]       s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    lexer_scoreboard sb;
    bit              src_rush = 1'b0;
    bit              snk_rush = 1'b0;
    int              cycles = 0;
    int              sent = 0;

    lexer_dfa_step_with_lookahead_unit i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    always
    begin : result_sink
        int unsigned stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                snk_rush = !snk_rush;
            stall = snk_rush ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    function automatic lex_item_t random_item();
        lex_item_t it;
        it.cmd      = 3'($urandom_range(0, 7));
        it.sym      = 8'($urandom);
        it.la_valid = 1'($urandom);
        it.la_sym   = 8'($urandom);
        it.row      = 6'($urandom);
        it.col      = 5'($urandom);
        it.tgt      = 8'($urandom);
        it.flag     = 1'($urandom);
        return it;
    endfunction

    // mostly characters that sit in the searched alphabet slots
    function automatic logic [SYM_W-1:0] pick_char();
        int lim;
        lim = sb.slots_searched();
        if (lim == 0 || $urandom_range(0, 4) == 0)
            return 8'($urandom);
        if (lim > 8 && $urandom_range(0, 3) != 0)
            lim = 8;
        return sb.alpha_sym[$urandom_range(0, lim - 1)];
    endfunction

    function automatic logic [COLIDX_W-1:0] pick_column();
        int nc;
        nc = sb.columns_used();
        if (nc > 0 && $urandom_range(0, 4) != 0)
            return 5'($urandom_range(0, nc - 1));
        return 5'($urandom);
    endfunction

    // mostly legal moves, with rejects and out-of-range targets mixed in
    function automatic logic [TGT_W-1:0] pick_target();
        int ns;
        int sel;
        ns  = sb.states_used();
        sel = $urandom_range(0, 9);
        if (sel < 7 && ns > 1)
            return 8'($urandom_range(1, ns - 1));
        if (sel == 7)
            return 8'(0 - int'($urandom_range(0, 128)));
        if (sel == 8 && ns <= 127)
            return 8'($urandom_range(ns, 127));
        return 8'($urandom);
    endfunction

    task automatic send_item(lex_item_t it);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0)
            src_rush = !src_rush;
        gap = src_rush ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= {3'b000, it.flag, it.tgt, it.col, it.row, it.la_sym, it.la_valid,
                          it.sym};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_input(it);
        sent++;
    endtask

    // load any table entry a step would read before it was ever written
    task automatic issue(lex_item_t it);
        lex_item_t fill;
        int        addr;
        while (sb.find_hole(it, addr))
        begin
            fill     = random_item();
            fill.cmd = CMD_TRANS;
            fill.row = 6'(addr / MAX_COLUMNS);
            fill.col = 5'(addr % MAX_COLUMNS);
            fill.tgt = pick_target();
            send_item(fill);
        end
        send_item(it);
    endtask

    task automatic alpha_load(int slot, logic [SYM_W-1:0] sym, logic [COLIDX_W-1:0] col);
        lex_item_t it;
        it     = random_item();
        it.cmd = CMD_ALPHA;
        it.row = 6'(slot);
        it.sym = sym;
        it.col = col;
        issue(it);
    endtask

    task automatic trans_load(int row, int col, logic [TGT_W-1:0] tgt);
        lex_item_t it;
        it     = random_item();
        it.cmd = CMD_TRANS;
        it.row = 6'(row);
        it.col = 5'(col);
        it.tgt = tgt;
        issue(it);
    endtask

    task automatic flag_load(int row, logic flag);
        lex_item_t it;
        it      = random_item();
        it.cmd  = CMD_ACCEPT;
        it.row  = 6'(row);
        it.flag = flag;
        issue(it);
    endtask

    task automatic step(logic [SYM_W-1:0] sym, logic la_valid, logic [SYM_W-1:0] la_sym);
        lex_item_t it;
        it          = random_item();
        it.cmd      = CMD_STEP;
        it.sym      = sym;
        it.la_valid = la_valid;
        it.la_sym   = la_sym;
        issue(it);
    endtask

    task automatic plain_cmd(logic [CMD_W-1:0] cmd);
        lex_item_t it;
        it     = random_item();
        it.cmd = cmd;
        issue(it);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 7'(value);
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, 7'(value));
    endtask

    task automatic write_settings(int ns, int nc, int nsym, int init);
        write_reg(CFG_NUM_STATES, ns);
        write_reg(CFG_NUM_COLUMNS, nc);
        write_reg(CFG_NUM_SYMBOLS, nsym);
        write_reg(CFG_START_STATE, init);
        cfg_valid <= 1'b0;
    endtask

    function automatic lex_item_t random_op();
        lex_item_t it;
        int        sel;
        int        ns;
        it  = random_item();
        sel = $urandom_range(0, 99);
        ns  = sb.states_used();
        if (sel < 70)
        begin
            it.cmd    = CMD_STEP;
            it.sym    = pick_char();
            it.la_sym = pick_char();
        end
        else if (sel < 78)
        begin
            it.cmd = CMD_ALPHA;
            it.col = pick_column();
        end
        else if (sel < 86)
        begin
            it.cmd = CMD_TRANS;
            it.col = pick_column();
            it.tgt = pick_target();
            if (ns > 0 && $urandom_range(0, 3) != 0)
                it.row = 6'($urandom_range(0, ns - 1));
        end
        else if (sel < 92)
            it.cmd = CMD_ACCEPT;
        else if (sel < 97)
            it.cmd = CMD_RESET;
        else
            it.cmd = 3'(CMD_RESET + $urandom_range(1, 3));
        return it;
    endfunction

    task automatic directed_part();
        // first match wins for a, c maps past the columns, z sits past the searched slots
        alpha_load(0, CH_A, 5'd0);
        alpha_load(1, CH_B, 5'd1);
        alpha_load(2, CH_A, 5'd1);
        alpha_load(3, CH_C, 5'd3);
        alpha_load(4, CH_Z, 5'd0);
        alpha_load(63, 8'hff, 5'd31);
        trans_load(0, 0, 8'sd1);
        trans_load(0, 1, 8'sd0);
        trans_load(1, 0, 8'sd3);
        trans_load(1, 1, -8'sd1);
        trans_load(2, 0, 8'sd4);
        trans_load(2, 1, 8'sd3);
        trans_load(3, 0, 8'sd1);
        trans_load(3, 1, 8'sd127);
        trans_load(63, 31, -8'sd128);
        flag_load(3, 1'b1);
        flag_load(1, 1'b0);
        flag_load(63, 1'b1);
        plain_cmd(CMD_RESET);
        step(CH_B, 1'b0, 8'h00);
        step(CH_A, 1'b1, CH_A);
        step(CH_B, 1'b0, 8'hff);
        step(8'hff, 1'b1, 8'hff);
        step(CH_C, 1'b0, 8'h00);
        step(CH_Z, 1'b0, 8'h00);
        step(CH_A, 1'b1, CH_C);
        step(CH_B, 1'b0, 8'h00);
        step(CH_A, 1'b1, CH_B);
        step(8'h00, 1'b1, CH_Z);
        plain_cmd(3'(CMD_RESET + 3));
        plain_cmd(CMD_RESET);
        step(CH_A, 1'b1, CH_A);
        step(CH_B, 1'b1, CH_Z);
    endtask

    // runs until the running total of sent transactions reaches item_goal
    task automatic random_phase(int ns, int nc, int nsym, int init, int item_goal);
        lex_item_t it;
        wait_idle();
        write_settings(ns, nc, nsym, init);
        // refresh the front of the alphabet so most characters map into the new columns
        for (int i = 0; i < 8; i++)
        begin
            if (i > 0 && $urandom_range(0, 9) == 0)
                alpha_load(i, sb.alpha_sym[$urandom_range(0, i - 1)], pick_column());
            else
                alpha_load(i, 8'($urandom), pick_column());
        end
        for (int i = 0; i < 16; i++)
        begin
            if (sb.states_used() > 16)
                flag_load($urandom_range(0, MAX_STATES - 1), 1'($urandom));
            else if (i < sb.states_used())
                flag_load(i, 1'($urandom));
        end
        while (sent < item_goal)
        begin
            it = random_op();
            issue(it);
        end
    endtask

    initial
    begin
        int base;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        write_settings(4, 2, 4, 2);
        for (int i = 0; i < ALPHA_SLOTS; i++)
            alpha_load(i, 8'($urandom), 5'($urandom));
        directed_part();
        base = sent;
        for (int p = 0; p < NUM_PHASES; p++)
            random_phase(phase_settings[p][0], phase_settings[p][1], phase_settings[p][2],
                         phase_settings[p][3],
                         base + (TOTAL_ITEMS - base) * (p + 1) / NUM_PHASES);
        wait_idle();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
